// ===== sv/welford_sigma_threshold_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the sigma threshold block
// Concurrent checks clocked by clock and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef WELFORD_SIGMA_THRESHOLD_MACROS_SVH
`define WELFORD_SIGMA_THRESHOLD_MACROS_SVH

// Same-cycle implication
`define WST_ASSERT_IMP(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication
`define WST_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== sv/wst_pkg.sv =====
// ----------------------------------------------------------------------------
// wst_pkg
// Types, widths and codes shared by the sigma threshold modules.
// ----------------------------------------------------------------------------
package wst_pkg;

   localparam int COUNT_BITS = 16;
   localparam int FRAC_BITS  = 8;
   localparam int Q_SHIFT    = 8;
   localparam int AXIS_W     = 16;
   localparam int SCALE_W    = 20;
   localparam int OUT_W      = 30;
   localparam int MEAN_W     = 40;
   localparam int SQ_W       = 64;
   localparam int ROOT_W     = 32;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 20;

   localparam logic [OUT_W-1:0] MAX_OUT = '1;
   localparam logic [OUT_W-1:0] ONE_Q8  = OUT_W'(256);

   localparam logic [CSR_ADDR_W-1:0] CSR_SCALE    = 3'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_OFFSET_X = 3'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_OFFSET_Y = 3'd2;
   localparam logic [CSR_ADDR_W-1:0] CSR_OFFSET_Z = 3'd3;
   localparam logic [CSR_ADDR_W-1:0] CSR_SIGMA    = 3'd4;

   localparam logic [1:0] AXIS_X = 2'd0;
   localparam logic [1:0] AXIS_Y = 2'd1;
   localparam logic [1:0] AXIS_Z = 2'd2;

   localparam logic SQRT_SRC_MAG = 1'b0;
   localparam logic SQRT_SRC_STD = 1'b1;
   localparam logic DIV_SRC_MEAN = 1'b0;
   localparam logic DIV_SRC_VAR  = 1'b1;

   typedef struct packed {
      logic                     command;
      logic signed [AXIS_W-1:0] accel_x;
      logic signed [AXIS_W-1:0] accel_y;
      logic signed [AXIS_W-1:0] accel_z;
   } req_type;

   typedef struct packed {
      logic [OUT_W-1:0]      magnitude;
      logic [OUT_W-1:0]      running_mean;
      logic [OUT_W-1:0]      std_dev;
      logic [OUT_W-1:0]      alarm_threshold;
      logic [COUNT_BITS-1:0] sample_count;
      logic                  threshold_valid;
   } rsp_type;

   typedef struct packed {
      logic       capture;
      logic       clear_stats;
      logic       axis_mul;
      logic       axis_sq;
      logic [1:0] axis_sel;
      logic       sqrt_start;
      logic       sqrt_src;
      logic       mag_take;
      logic       delta;
      logic       div_start;
      logic       div_src;
      logic       mean_upd;
      logic       prod;
      logic       accum;
      logic       std_take;
      logic       thr_lo;
      logic       thr_hi;
      logic       thr_fin;
      logic       load_out;
   } cmd_type;

   typedef struct packed {
      logic cmd_clear;
      logic sqrt_done;
      logic div_done;
      logic count_gt1;
   } status_type;

endpackage

// ===== sv/wst_div.sv =====
// ----------------------------------------------------------------------------
// wst_div
// Restoring divider, one quotient bit per cycle, 64-bit by COUNT_BITS.
// ----------------------------------------------------------------------------
module wst_div (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   input  logic [wst_pkg::SQ_W-1:0]        dividend,
   input  logic [wst_pkg::COUNT_BITS-1:0]  divisor,
   output logic [wst_pkg::SQ_W-1:0]        quotient,
   output logic                            done
);

   localparam int CNT_W = $clog2(wst_pkg::SQ_W);
   localparam int DW    = wst_pkg::COUNT_BITS;

   logic                    busy_ff, busy_in;
   logic                    done_ff, done_in;
   logic [CNT_W-1:0]        cnt_ff, cnt_in;
   logic [wst_pkg::SQ_W-1:0] quo_ff, quo_in;
   logic [DW-1:0]           rem_ff, rem_in;
   logic [DW-1:0]           dvs_ff, dvs_in;
   logic [DW:0]             rem_sh;
   logic [DW:0]             rem_sub;
   logic                    ge;

   always_comb begin
      rem_sh  = {rem_ff, quo_ff[wst_pkg::SQ_W-1]};
      ge      = rem_sh >= {1'b0, dvs_ff};
      rem_sub = rem_sh - {1'b0, dvs_ff};
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         quo_in  = dividend;
         rem_in  = '0;
         dvs_in  = divisor;
      end else if (busy_ff) begin
         quo_in = {quo_ff[wst_pkg::SQ_W-2:0], ge};
         rem_in = ge ? rem_sub[DW-1:0] : rem_sh[DW-1:0];
         cnt_in = cnt_ff + CNT_W'(1);
         if (cnt_ff == CNT_W'(wst_pkg::SQ_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   assign quotient = quo_ff;
   assign done     = done_ff;

endmodule

// ===== sv/wst_sqrt.sv =====
// ----------------------------------------------------------------------------
// wst_sqrt
// Integer square root, one result bit per cycle, 64-bit radicand.
// ----------------------------------------------------------------------------
module wst_sqrt (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [wst_pkg::SQ_W-1:0]    radicand,
   output logic [wst_pkg::ROOT_W-1:0]  root,
   output logic                        done
);

   localparam int W     = wst_pkg::SQ_W;
   localparam int CNT_W = $clog2(wst_pkg::ROOT_W);

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [W-1:0]     x_ff, x_in;
   logic [W-1:0]     r_ff, r_in;
   logic [W-1:0]     bit_ff, bit_in;
   logic [W-1:0]     trial;

   always_comb begin
      trial   = r_ff + bit_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      x_in    = x_ff;
      r_in    = r_ff;
      bit_in  = bit_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         x_in    = radicand;
         r_in    = '0;
         bit_in  = W'(1) << (W - 2);
      end else if (busy_ff) begin
         if (x_ff >= trial) begin
            x_in = x_ff - trial;
            r_in = (r_ff >> 1) + bit_ff;
         end else begin
            r_in = r_ff >> 1;
         end
         bit_in = bit_ff >> 2;
         cnt_in = cnt_ff + CNT_W'(1);
         if (cnt_ff == CNT_W'(wst_pkg::ROOT_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      x_ff   <= x_in;
      r_ff   <= r_in;
      bit_ff <= bit_in;
   end

   assign root = r_ff[wst_pkg::ROOT_W-1:0];
   assign done = done_ff;

endmodule

// ===== sv/wst_dp.sv =====
// ----------------------------------------------------------------------------
// wst_dp
// Datapath: axis scaling, magnitude, Welford update and threshold.
// ----------------------------------------------------------------------------
module wst_dp (
   input  logic                                clock,
   input  logic                                reset,
   input  wst_pkg::req_type                    req_data,
   input  logic                                csr_wr_en,
   input  logic [wst_pkg::CSR_ADDR_W-1:0]      csr_index,
   input  logic [wst_pkg::CSR_DATA_W-1:0]      csr_wdata,
   input  wst_pkg::cmd_type                    cmd,
   output wst_pkg::status_type                 status,
   output wst_pkg::rsp_type                    rsp_data
);

   localparam int P_W   = wst_pkg::AXIS_W + wst_pkg::SCALE_W + 1;
   localparam int C_W   = 30;
   localparam int A_W   = C_W - 1;
   localparam int SS_W  = 2 * A_W + 2;
   localparam int HALF  = wst_pkg::ROOT_W / 2;
   localparam int T_W   = wst_pkg::SCALE_W + HALF;
   localparam int SUM_W = T_W + 2;
   localparam int CB    = wst_pkg::COUNT_BITS;

   // configuration
   logic [wst_pkg::SCALE_W-1:0]       scale_ff;
   logic signed [wst_pkg::AXIS_W-1:0] offx_ff, offy_ff, offz_ff;
   logic [wst_pkg::SCALE_W-1:0]       sigma_ff;

   // item and working registers
   wst_pkg::req_type               in_ff;
   logic signed [P_W-1:0]          p_ff;
   logic [SS_W-1:0]                sumsq_ff;
   logic [wst_pkg::OUT_W-1:0]      mag_ff;
   logic [CB-1:0]                  count_ff;
   logic [wst_pkg::MEAN_W-1:0]     mean_ff;
   logic                           neg_ff;
   logic [wst_pkg::MEAN_W-1:0]     d_ff, e_ff;
   logic [wst_pkg::SQ_W-1:0]       prod_ff, sq_ff;
   logic [wst_pkg::ROOT_W-1:0]     std_ff;
   logic [T_W-1:0]                 tl_ff, th_ff;
   logic [wst_pkg::OUT_W-1:0]      thr_ff;
   logic                           valid_ff;
   wst_pkg::rsp_type               rsp_ff;

   // combinational
   logic signed [wst_pkg::AXIS_W-1:0] raw_sel, off_sel;
   logic signed [P_W-1:0]             p_in;
   logic signed [P_W-1:0]             p_shr;
   logic signed [C_W-1:0]             comp;
   logic [A_W-1:0]                    comp_abs;
   logic [2*A_W-1:0]                  comp_sq;
   logic [SS_W-1:0]                   sumsq_in;
   logic [wst_pkg::SQ_W-1:0]          sqrt_arg, div_arg;
   logic [CB-1:0]                     div_dvs;
   logic [wst_pkg::ROOT_W-1:0]        root;
   logic                              sqrt_done;
   logic [wst_pkg::SQ_W-1:0]          quo;
   logic                              div_done;
   logic [CB-1:0]                     count_inc;
   logic [wst_pkg::MEAN_W-1:0]        v_in;
   logic [wst_pkg::MEAN_W-1:0]        q_mean;
   logic [wst_pkg::SQ_W:0]            acc_sum;
   logic [SUM_W-1:0]                  thr_sum;
   logic [wst_pkg::OUT_W-1:0]         std_sat;

   always_comb begin
      case (cmd.axis_sel)
         wst_pkg::AXIS_X: begin
            raw_sel = in_ff.accel_x;
            off_sel = offx_ff;
         end
         wst_pkg::AXIS_Y: begin
            raw_sel = in_ff.accel_y;
            off_sel = offy_ff;
         end
         default: begin
            raw_sel = in_ff.accel_z;
            off_sel = offz_ff;
         end
      endcase
   end

   assign p_in     = raw_sel * $signed({1'b0, scale_ff});
   assign p_shr    = p_ff >>> wst_pkg::Q_SHIFT;
   assign comp     = p_shr[C_W-1:0] +
                     $signed({{(C_W - wst_pkg::AXIS_W - wst_pkg::Q_SHIFT){off_sel[15]}},
                              off_sel, {wst_pkg::Q_SHIFT{1'b0}}});
   assign comp_abs = comp[C_W-1] ? A_W'(-comp) : A_W'(comp);
   assign comp_sq  = comp_abs * comp_abs;
   assign sumsq_in = ((cmd.axis_sel == wst_pkg::AXIS_X) ? '0 : sumsq_ff) + SS_W'(comp_sq);

   assign sqrt_arg = (cmd.sqrt_src == wst_pkg::SQRT_SRC_MAG) ? wst_pkg::SQ_W'(sumsq_ff) : quo;
   assign div_arg  = (cmd.div_src == wst_pkg::DIV_SRC_MEAN) ? wst_pkg::SQ_W'(d_ff) : sq_ff;
   assign div_dvs  = (cmd.div_src == wst_pkg::DIV_SRC_MEAN) ? count_ff : count_ff - CB'(1);

   wst_sqrt u_sqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.sqrt_start),
      .radicand (sqrt_arg),
      .root     (root),
      .done     (sqrt_done)
   );

   wst_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (div_arg),
      .divisor  (div_dvs),
      .quotient (quo),
      .done     (div_done)
   );

   assign count_inc = count_ff + CB'(1);
   assign v_in      = wst_pkg::MEAN_W'(mag_ff) << wst_pkg::FRAC_BITS;
   assign q_mean    = quo[wst_pkg::MEAN_W-1:0];
   assign acc_sum   = {1'b0, sq_ff} + {1'b0, prod_ff};
   assign thr_sum   = SUM_W'(mean_ff[wst_pkg::MEAN_W-1:wst_pkg::FRAC_BITS]) + SUM_W'(th_ff)
                      + SUM_W'(tl_ff[T_W-1:HALF]);
   assign std_sat   = (std_ff[wst_pkg::ROOT_W-1:wst_pkg::OUT_W] != '0) ? wst_pkg::MAX_OUT
                      : std_ff[wst_pkg::OUT_W-1:0];

   // configuration writes; unknown indexes drop
   always_ff @(posedge clock) begin
      if (reset) begin
         scale_ff <= wst_pkg::SCALE_W'(65536);
         offx_ff  <= '0;
         offy_ff  <= '0;
         offz_ff  <= '0;
         sigma_ff <= wst_pkg::SCALE_W'(196608);
      end else if (csr_wr_en) begin
         unique case (csr_index)
            wst_pkg::CSR_SCALE:    scale_ff <= csr_wdata;
            wst_pkg::CSR_OFFSET_X: offx_ff  <= csr_wdata[wst_pkg::AXIS_W-1:0];
            wst_pkg::CSR_OFFSET_Y: offy_ff  <= csr_wdata[wst_pkg::AXIS_W-1:0];
            wst_pkg::CSR_OFFSET_Z: offz_ff  <= csr_wdata[wst_pkg::AXIS_W-1:0];
            wst_pkg::CSR_SIGMA:    sigma_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // statistics
   always_ff @(posedge clock) begin
      if (reset) begin
         mean_ff  <= '0;
         sq_ff    <= '0;
         count_ff <= '0;
         thr_ff   <= wst_pkg::ONE_Q8;
      end else begin
         if (cmd.clear_stats) begin
            mean_ff  <= '0;
            sq_ff    <= '0;
            count_ff <= '0;
            thr_ff   <= wst_pkg::ONE_Q8;
         end
         if (cmd.mag_take) begin
            if (count_inc == '0) begin
               mean_ff  <= '0;
               sq_ff    <= '0;
               count_ff <= CB'(1);
               thr_ff   <= wst_pkg::ONE_Q8;
            end else begin
               count_ff <= count_inc;
            end
         end
         if (cmd.mean_upd) begin
            mean_ff <= neg_ff ? mean_ff - q_mean : mean_ff + q_mean;
         end
         if (cmd.accum) begin
            sq_ff <= acc_sum[wst_pkg::SQ_W] ? '1 : acc_sum[wst_pkg::SQ_W-1:0];
         end
         if (cmd.thr_fin) begin
            thr_ff <= (thr_sum > SUM_W'(wst_pkg::MAX_OUT)) ? wst_pkg::MAX_OUT
                      : thr_sum[wst_pkg::OUT_W-1:0];
         end
      end
   end

   // working registers
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         in_ff    <= req_data;
         std_ff   <= '0;
         valid_ff <= 1'b0;
      end
      if (cmd.clear_stats) begin
         mag_ff <= '0;
      end
      if (cmd.axis_mul) begin
         p_ff <= p_in;
      end
      if (cmd.axis_sq) begin
         sumsq_ff <= sumsq_in;
      end
      if (cmd.mag_take) begin
         mag_ff <= root[wst_pkg::OUT_W-1:0];
      end
      if (cmd.delta) begin
         neg_ff <= v_in < mean_ff;
         d_ff   <= (v_in < mean_ff) ? mean_ff - v_in : v_in - mean_ff;
      end
      if (cmd.mean_upd) begin
         e_ff <= d_ff - q_mean;
      end
      if (cmd.prod) begin
         prod_ff <= wst_pkg::SQ_W'(d_ff[wst_pkg::MEAN_W-1:wst_pkg::FRAC_BITS])
                    * wst_pkg::SQ_W'(e_ff[wst_pkg::MEAN_W-1:wst_pkg::FRAC_BITS]);
      end
      if (cmd.std_take) begin
         std_ff <= root;
      end
      if (cmd.thr_lo) begin
         tl_ff <= sigma_ff * std_ff[HALF-1:0];
      end
      if (cmd.thr_hi) begin
         th_ff <= sigma_ff * std_ff[wst_pkg::ROOT_W-1:HALF];
      end
      if (cmd.thr_fin) begin
         valid_ff <= 1'b1;
      end
      if (cmd.load_out) begin
         rsp_ff.magnitude       <= mag_ff;
         rsp_ff.running_mean    <= mean_ff[wst_pkg::FRAC_BITS +: wst_pkg::OUT_W];
         rsp_ff.std_dev         <= std_sat;
         rsp_ff.alarm_threshold <= thr_ff;
         rsp_ff.sample_count    <= count_ff;
         rsp_ff.threshold_valid <= valid_ff;
      end
   end

   assign status.cmd_clear = in_ff.command;
   assign status.sqrt_done = sqrt_done;
   assign status.div_done  = div_done;
   assign status.count_gt1 = count_ff > CB'(1);
   assign rsp_data         = rsp_ff;

endmodule

// ===== sv/wst_ctrl.sv =====
// ----------------------------------------------------------------------------
// wst_ctrl
// Sequencer for one request at a time and the result valid flag.
// ----------------------------------------------------------------------------
`include "welford_sigma_threshold_macros.svh"

module wst_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   input  wst_pkg::status_type  status,
   output wst_pkg::cmd_type     cmd
);

   typedef enum logic [18:0] {
      S_IDLE  = 19'h00001,
      S_DISP  = 19'h00002,
      S_MUL   = 19'h00004,
      S_SQ    = 19'h00008,
      S_MAGS  = 19'h00010,
      S_MAGW  = 19'h00020,
      S_DELTA = 19'h00040,
      S_MDIVS = 19'h00080,
      S_MDIVW = 19'h00100,
      S_PROD  = 19'h00200,
      S_ACC   = 19'h00400,
      S_VDIVS = 19'h00800,
      S_VDIVW = 19'h01000,
      S_SSQS  = 19'h02000,
      S_SSQW  = 19'h04000,
      S_THRL  = 19'h08000,
      S_THRH  = 19'h10000,
      S_THRF  = 19'h20000,
      S_OUT   = 19'h40000
   } state_type;

   state_type  state_ff, state_in;
   logic [1:0] axis_ff, axis_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       out_free;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != S_IDLE);

   always_comb begin
      cmd          = '0;
      cmd.axis_sel = axis_ff;
      state_in     = state_ff;
      axis_in      = axis_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = S_DISP;
            end
         end
         S_DISP: begin
            if (status.cmd_clear) begin
               cmd.clear_stats = 1'b1;
               state_in        = S_OUT;
            end else begin
               axis_in  = wst_pkg::AXIS_X;
               state_in = S_MUL;
            end
         end
         S_MUL: begin
            cmd.axis_mul = 1'b1;
            state_in     = S_SQ;
         end
         S_SQ: begin
            cmd.axis_sq = 1'b1;
            if (axis_ff == wst_pkg::AXIS_Z) begin
               state_in = S_MAGS;
            end else begin
               axis_in  = axis_ff + 2'd1;
               state_in = S_MUL;
            end
         end
         S_MAGS: begin
            cmd.sqrt_start = 1'b1;
            cmd.sqrt_src   = wst_pkg::SQRT_SRC_MAG;
            state_in       = S_MAGW;
         end
         S_MAGW: begin
            if (status.sqrt_done) begin
               cmd.mag_take = 1'b1;
               state_in     = S_DELTA;
            end
         end
         S_DELTA: begin
            cmd.delta = 1'b1;
            state_in  = S_MDIVS;
         end
         S_MDIVS: begin
            cmd.div_start = 1'b1;
            cmd.div_src   = wst_pkg::DIV_SRC_MEAN;
            state_in      = S_MDIVW;
         end
         S_MDIVW: begin
            if (status.div_done) begin
               cmd.mean_upd = 1'b1;
               state_in     = S_PROD;
            end
         end
         S_PROD: begin
            cmd.prod = 1'b1;
            state_in = S_ACC;
         end
         S_ACC: begin
            cmd.accum = 1'b1;
            state_in  = status.count_gt1 ? S_VDIVS : S_OUT;
         end
         S_VDIVS: begin
            cmd.div_start = 1'b1;
            cmd.div_src   = wst_pkg::DIV_SRC_VAR;
            state_in      = S_VDIVW;
         end
         S_VDIVW: begin
            if (status.div_done) begin
               state_in = S_SSQS;
            end
         end
         S_SSQS: begin
            cmd.sqrt_start = 1'b1;
            cmd.sqrt_src   = wst_pkg::SQRT_SRC_STD;
            state_in       = S_SSQW;
         end
         S_SSQW: begin
            if (status.sqrt_done) begin
               cmd.std_take = 1'b1;
               state_in     = S_THRL;
            end
         end
         S_THRL: begin
            cmd.thr_lo = 1'b1;
            state_in   = S_THRH;
         end
         S_THRH: begin
            cmd.thr_hi = 1'b1;
            state_in   = S_THRF;
         end
         S_THRF: begin
            cmd.thr_fin = 1'b1;
            state_in    = S_OUT;
         end
         S_OUT: begin
            if (out_free) begin
               cmd.load_out = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.load_out) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         axis_ff      <= wst_pkg::AXIS_X;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         axis_ff      <= axis_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   `WST_ASSERT_IMP(a_no_overwrite, rsp_valid_ff && rsp_stall, !cmd.load_out, "result overwritten while stalled")
   `WST_ASSERT_NEXT(a_load_shows, cmd.load_out, rsp_valid_ff, "loaded result not presented")
   `WST_ASSERT_IMP(a_sqrt_done_wait, status.sqrt_done, state_ff == S_MAGW || state_ff == S_SSQW, "root finished outside a wait state")
   `WST_ASSERT_IMP(a_div_done_wait, status.div_done, state_ff == S_MDIVW || state_ff == S_VDIVW, "quotient finished outside a wait state")

endmodule

// ===== sv/welford_sigma_threshold.sv =====
// ----------------------------------------------------------------------------
// welford_sigma_threshold
// Accelerometer magnitude with running mean, deviation and alarm threshold.
// ----------------------------------------------------------------------------
//
//   channel   ports                              direction
//   --------  ---------------------------------  ---------
//   request   req_valid / req_stall / req_data   in
//   result    rsp_valid / rsp_stall / rsp_data   out
//   config    csr_wr_en / csr_index / csr_wdata  in
//
// A sample request uses the shared bit-serial square root for the magnitude
// and the shared bit-serial divider for the mean; when the count is above
// one it runs a second pass of each, the divider for the variance and the
// square root for the deviation. A clear request skips the arithmetic.
// Reset is synchronous: registers return to their reset values, statistics
// clear and the threshold reads 1.0 (256).
// The block takes the next request while a finished result waits under stall.
// ----------------------------------------------------------------------------
module welford_sigma_threshold (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  wst_pkg::req_type                  req_data,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output wst_pkg::rsp_type                  rsp_data,
   input  logic                              csr_wr_en,
   input  logic [wst_pkg::CSR_ADDR_W-1:0]    csr_index,
   input  logic [wst_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   // command and status between sequencer and datapath
   wst_pkg::cmd_type    cmd;
   wst_pkg::status_type status;

   // sequencer: handshakes, step order, result valid
   wst_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   // datapath: config registers, arithmetic, statistics, result register
   wst_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cmd       (cmd),
      .status    (status),
      .rsp_data  (rsp_data)
   );

endmodule
